// ===== src/sps_pkg.sv =====
// shared widths, codes and types for the partial shuffle sampler
package sps_pkg;

  localparam int COUNT_W   = 9;
  localparam int IDX_W     = 8;
  localparam int STAT_W    = 2;
  localparam int WORD_W    = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic FUNC_RESTART = 1'b0;
  localparam logic FUNC_WORD    = 1'b1;

  localparam logic [STAT_W-1:0] ST_PICKED   = 2'd0;
  localparam logic [STAT_W-1:0] ST_REJECTED = 2'd1;
  localparam logic [STAT_W-1:0] ST_COMPLETE = 2'd2;
  localparam logic [STAT_W-1:0] ST_RESTART  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_ITEM_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PICK_COUNT = 1'b1;

  typedef struct packed {
    logic               done;
    logic               reject;
    logic [COUNT_W-1:0] rem;
  } sps_div_res_t;

endpackage

// ===== src/partial_shuffle_sampler.sv =====
// partial fisher-yates sampler: sequencer, slot store and result register
//
//  channel   direction  handshake           payload
//  in_       input      in_valid/in_stall   in_func, in_random_word
//  out_      output     out_valid/out_stall out_picked_index, out_status, out_last_pick
//  cfg_      input      cfg_we              cfg_index, cfg_data
//
// an accepted item reaches the output register by these steps: a pick runs the remainder unit
// (one quotient bit per cycle), then the slot swap through the ram port in S_RD_A, S_RD_B,
// S_WR_A and S_WR_B; a rejected word runs the remainder unit only; a finished draw is settled in
// S_CHECK; a restart sweeps the written flags one slot a cycle. after reset the same sweep
// runs over every slot before the first item is taken.
// a finished result waits in the output register; the next item is taken meanwhile.
module partial_shuffle_sampler import sps_pkg::*; #(
  parameter int TABLE_DEPTH = 256,
  parameter int RAND_BITS   = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_func,
  input  logic [WORD_W-1:0]    in_random_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [IDX_W-1:0]     out_picked_index,
  output logic [STAT_W-1:0]    out_status,
  output logic                 out_last_pick,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COUNT_W-1:0]   cfg_data
);

  localparam int IW  = $clog2(TABLE_DEPTH);
  localparam int CAP = (TABLE_DEPTH < 511) ? TABLE_DEPTH : 511;
  localparam logic [COUNT_W-1:0] CAP_C   = COUNT_W'(CAP);
  localparam logic [IW-1:0]      LAST_SL = IW'(TABLE_DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_CLEAR, S_DIV, S_RD_A, S_RD_B, S_WR_A, S_WR_B
  } state_t;

  state_t state_r;
  logic                 fin_r;
  logic                 func_r;
  logic [RAND_BITS-1:0] word_r;
  logic [COUNT_W-1:0]   item_count_r;
  logic [COUNT_W-1:0]   pick_count_r;
  logic [COUNT_W-1:0]   pos_r;
  logic [COUNT_W-1:0]   j_r;
  logic [IW-1:0]        clr_cnt_r;
  logic [IW-1:0]        a_r;
  logic [IDX_W-1:0]     pend_idx_r;
  logic [STAT_W-1:0]    pend_stat_r;
  logic                 pend_last_r;
  logic                 out_valid_r;
  logic [IDX_W-1:0]     out_idx_r;
  logic [STAT_W-1:0]    out_stat_r;
  logic                 out_last_r;

  logic [COUNT_W-1:0] n_w;
  logic [COUNT_W-1:0] picks_w;
  logic [COUNT_W-1:0] m_w;
  logic               div_start;
  sps_div_res_t       div_res;
  logic [IW-1:0]      pos_addr;
  logic [IW-1:0]      j_addr;
  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  logic [IW:0]        ram_wdata;
  logic [IW-1:0]      ram_raddr;
  logic [IW:0]        ram_rdata;
  logic [IW-1:0]      slot_val;
  logic               out_free;

  always_comb begin
    n_w       = (item_count_r < CAP_C) ? item_count_r : CAP_C;
    picks_w   = (pick_count_r < n_w) ? pick_count_r : n_w;
    m_w       = n_w - pos_r;
    pos_addr  = IW'(pos_r);
    j_addr    = IW'(j_r);
    div_start = (state_r == S_CHECK) && (func_r == FUNC_WORD) && (pos_r < picks_w);
    out_free  = !out_valid_r || !out_stall;
    // an unwritten slot reads as its own index
    slot_val  = ram_rdata[IW] ? ram_rdata[IW-1:0] :
                ((state_r == S_RD_B) ? pos_addr : j_addr);
    ram_raddr = (state_r == S_RD_B) ? j_addr : pos_addr;
    ram_we    = 1'b0;
    ram_waddr = clr_cnt_r;
    ram_wdata = '0;
    case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_WR_A: begin
        ram_we    = 1'b1;
        ram_waddr = pos_addr;
        ram_wdata = {1'b1, slot_val};
      end
      S_WR_B: begin
        ram_we    = 1'b1;
        ram_waddr = j_addr;
        ram_wdata = {1'b1, a_r};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  sps_ram #(
    .WIDTH (IW + 1),
    .DEPTH (TABLE_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sps_divider #(
    .RAND_BITS (RAND_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .m     (m_w),
    .word  (word_r),
    .res   (div_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_count_r <= COUNT_W'(1);
      pick_count_r <= COUNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ITEM_COUNT: item_count_r <= cfg_data;
        REG_PICK_COUNT: pick_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      fin_r       <= 1'b0;
      func_r      <= FUNC_WORD;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // pending result moves to the output register once it is free
      if (fin_r && out_free) begin
        fin_r       <= 1'b0;
        out_valid_r <= 1'b1;
        out_idx_r   <= pend_idx_r;
        out_stat_r  <= pend_stat_r;
        out_last_r  <= pend_last_r;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid && !fin_r) begin
            func_r  <= in_func;
            word_r  <= RAND_BITS'(in_random_word);
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          pend_idx_r  <= '0;
          pend_last_r <= 1'b0;
          if (func_r == FUNC_RESTART) begin
            clr_cnt_r <= '0;
            state_r   <= S_CLEAR;
          end else if (pos_r >= picks_w) begin
            pend_stat_r <= ST_COMPLETE;
            fin_r       <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == LAST_SL) begin
            pos_r   <= '0;
            state_r <= S_IDLE;
            if (func_r == FUNC_RESTART) begin
              pend_idx_r  <= '0;
              pend_last_r <= 1'b0;
              pend_stat_r <= ST_RESTART;
              fin_r       <= 1'b1;
            end
          end
        end
        S_DIV: begin
          if (div_res.done) begin
            if (div_res.reject) begin
              pend_stat_r <= ST_REJECTED;
              fin_r       <= 1'b1;
              state_r     <= S_IDLE;
            end else begin
              j_r     <= COUNT_W'(pos_r + div_res.rem);
              state_r <= S_RD_A;
            end
          end
        end
        S_RD_A: begin
          state_r <= S_RD_B;
        end
        S_RD_B: begin
          a_r     <= slot_val;
          state_r <= S_WR_A;
        end
        S_WR_A: begin
          pend_idx_r <= IDX_W'(slot_val);
          state_r    <= S_WR_B;
        end
        S_WR_B: begin
          pos_r       <= COUNT_W'(pos_r + 1'b1);
          pend_stat_r <= ST_PICKED;
          pend_last_r <= (COUNT_W'(pos_r + 1'b1) == picks_w);
          fin_r       <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall         = (state_r != S_IDLE) || fin_r;
  assign out_valid        = out_valid_r;
  assign out_picked_index = out_idx_r;
  assign out_status       = out_stat_r;
  assign out_last_pick    = out_last_r;

endmodule

// ===== src/sps_ram.sv =====
// generic single write port ram with registered read
module sps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/sps_divider.sv =====
// bit-serial remainder of the word and of the all-ones maximum by m, with rejection test
module sps_divider import sps_pkg::*; #(
  parameter int RAND_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [COUNT_W-1:0]   m,
  input  logic [RAND_BITS-1:0] word,
  output sps_div_res_t         res
);

  localparam int CW = $clog2(RAND_BITS + 1);

  logic                 busy_r;
  logic                 done_r;
  logic [CW-1:0]        cnt_r;
  logic [RAND_BITS-1:0] word_sr_r;
  logic [COUNT_W-1:0]   m_r;
  logic [COUNT_W-1:0]   rw_r;
  logic [COUNT_W-1:0]   rm_r;
  logic                 eq_r;

  logic [COUNT_W:0]   tw;
  logic [COUNT_W:0]   tm;
  logic               ge_w;
  logic               ge_m;
  logic [COUNT_W-1:0] rw_nxt;
  logic [COUNT_W-1:0] rm_nxt;

  always_comb begin
    tw     = {rw_r, word_sr_r[RAND_BITS-1]};
    tm     = {rm_r, 1'b1};
    ge_w   = tw >= {1'b0, m_r};
    ge_m   = tm >= {1'b0, m_r};
    rw_nxt = ge_w ? COUNT_W'(tw - {1'b0, m_r}) : tw[COUNT_W-1:0];
    rm_nxt = ge_m ? COUNT_W'(tm - {1'b0, m_r}) : tm[COUNT_W-1:0];
  end

  // word is rejected when its quotient equals the quotient of the maximum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        word_sr_r <= {word_sr_r[RAND_BITS-2:0], 1'b0};
        rw_r      <= rw_nxt;
        rm_r      <= rm_nxt;
        eq_r      <= eq_r & (ge_w == ge_m);
        cnt_r     <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (start) begin
        busy_r    <= 1'b1;
        word_sr_r <= word;
        m_r       <= m;
        rw_r      <= '0;
        rm_r      <= '0;
        eq_r      <= 1'b1;
        cnt_r     <= CW'(RAND_BITS);
      end
    end
  end

  assign res.done   = done_r;
  assign res.reject = eq_r;
  assign res.rem    = rw_r;

endmodule
